/* sv/soa_pkg.sv */
// soa_pkg: shared types and constants for the slot owner allocator
// used by soa_ctrl, soa_dp and slot_owner_allocator; no dependencies
package soa_pkg;

  // fixed field widths of the item and result
  localparam int OPCODE_W = 3;
  localparam int SLOT_W   = 9;
  localparam int OWNER_W  = 16;
  localparam int STATUS_W = 3;

  // occupancy bitmap row geometry
  localparam int ROW_W = 16;
  localparam int COL_W = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TAKE_FIRST = 3'd0,
    OP_TAKE_NAMED = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_READ       = 3'd3,
    OP_GROUP      = 3'd4,
    OP_CLEAR      = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_BAD       = 3'd1,
    STS_BUSY      = 3'd2,
    STS_FREE      = 3'd3,
    STS_GROUP_BIG = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the accepted item
    logic look;   // row search and owner memory read
    logic exec;   // decide, update table, load result register
  } soa_cmd_t;

endpackage

/* sv/soa_ctrl.sv */
// soa_ctrl: sequencer for one item at a time through look and exec steps
// depends on soa_pkg for the command struct
module soa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output soa_pkg::soa_cmd_t cmd
);
  import soa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // result register may be refilled when empty or being taken
  assign out_free = !out_valid || out_ready;

  always_comb begin
    in_ready   = (state == S_IDLE) || ((state == S_EXEC) && out_free);
    cmd.load   = in_valid && in_ready;
    cmd.look   = (state == S_LOOK);
    cmd.exec   = (state == S_EXEC) && out_free;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_LOOK;
      end
      S_LOOK: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = cmd.load ? S_LOOK : S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_load_to_look: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_LOOK))
    else $error("accepted item did not move to look step");
  a_exec_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("finished item left no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.exec)
    else $error("result register overwritten while stalled");
`endif

endmodule

/* sv/soa_dp.sv */
// soa_dp: item register, occupancy bitmap, owner memory, counters, result register
// depends on soa_pkg; driven by soa_ctrl commands
module soa_dp #(
  parameter int MAX_SLOTS  = 256,
  parameter int OWNER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  soa_pkg::soa_cmd_t             cmd,
  input  logic                          cfg_we,
  input  logic [soa_pkg::SLOT_W-1:0]    cfg_data,
  input  logic [soa_pkg::OPCODE_W-1:0]  opcode,
  input  logic [soa_pkg::SLOT_W-1:0]    slot,
  input  logic [soa_pkg::OWNER_W-1:0]   owner,
  input  logic [soa_pkg::SLOT_W-1:0]    group_size,
  input  logic                          group_last,
  output logic [soa_pkg::STATUS_W-1:0]  status,
  output logic [soa_pkg::SLOT_W-1:0]    slot_out,
  output logic [soa_pkg::OWNER_W-1:0]   owner_out,
  output logic [soa_pkg::SLOT_W-1:0]    occupied,
  output logic [soa_pkg::SLOT_W-1:0]    free_slots,
  output logic [soa_pkg::SLOT_W-1:0]    group_seated
);
  import soa_pkg::*;

  localparam int NROWS     = (MAX_SLOTS + ROW_W - 1) / ROW_W;
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int IW        = RW + COL_W;
  localparam int CW        = (IW > SLOT_W) ? IW : SLOT_W;
  localparam int AW        = $clog2(MAX_SLOTS);
  localparam int OW        = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
  localparam int CAP_LIMIT = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
  localparam int CAP_RST   = (MAX_SLOTS > 256) ? 256 : MAX_SLOTS;

  // item register
  opcode_t           it_op;
  logic [SLOT_W-1:0] it_slot;
  logic [OW-1:0]     it_own;
  logic [SLOT_W-1:0] it_gsize;
  logic              it_glast;

  // table state
  logic [ROW_W-1:0]  occ [NROWS];
  logic [OW-1:0]     mem [MAX_SLOTS];
  logic [OW-1:0]     rd_owner;
  logic [SLOT_W-1:0] cap;
  logic [SLOT_W-1:0] occ_cnt;
  logic              g_open;
  logic              g_rej;
  logic [SLOT_W-1:0] g_cnt;

  // look step registers
  logic [RW-1:0]     row_reg;
  logic              look_any;

  // combinational
  logic [SLOT_W-1:0] sl_m1;
  logic              in_range;
  logic              use_search;
  logic [RW-1:0]     srch_row;
  logic              srch_any;
  logic [ROW_W-1:0]  row_bits;
  logic [COL_W-1:0]  ff_col;
  logic [COL_W-1:0]  sl_col;
  logic [IW-1:0]     ff_idx;
  logic              ff_ok;
  logic [SLOT_W-1:0] ff_slot;
  logic              sl_busy;
  logic [SLOT_W-1:0] free_now;
  logic [SLOT_W-1:0] cap_wr;

  status_t           x_status;
  logic [SLOT_W-1:0] x_slot;
  logic [OWNER_W-1:0] x_owner;
  logic [SLOT_W-1:0] x_seated;
  logic              set_en;
  logic              clr_en;
  logic              clr_all;
  logic              set_first;
  logic [SLOT_W-1:0] occ_next;
  logic              g_open_next;
  logic              g_rej_next;
  logic [SLOT_W-1:0] g_cnt_next;
  logic              g_first;
  logic              g_reject;
  logic [SLOT_W-1:0] g_base;
  logic              wipe;

  // slot decode
  assign sl_m1    = it_slot - 9'd1;
  assign in_range = (it_slot != '0) && (it_slot <= cap);
  assign sl_col   = sl_m1[COL_W-1:0];
  assign use_search = (it_op == OP_TAKE_FIRST) || (it_op == OP_GROUP);
  assign free_now = cap - occ_cnt;
  assign cap_wr   = (cfg_data > CAP_LIMIT[SLOT_W-1:0]) ? CAP_LIMIT[SLOT_W-1:0] : cfg_data;

  // first row that still has a free bit
  always_comb begin
    srch_row = '0;
    srch_any = 1'b0;
    for (int r = NROWS - 1; r >= 0; r--) begin
      if (!(&occ[r])) begin
        srch_row = RW'(r);
        srch_any = 1'b1;
      end
    end
  end

  // first free bit within the chosen row
  assign row_bits = occ[row_reg];
  always_comb begin
    ff_col = '0;
    for (int c = ROW_W - 1; c >= 0; c--) begin
      if (!row_bits[c]) ff_col = COL_W'(c);
    end
  end

  assign ff_idx  = {row_reg, ff_col};
  assign ff_ok   = look_any && (CW'(ff_idx) < CW'(cap));
  assign ff_slot = SLOT_W'(ff_idx) + 9'd1;
  assign sl_busy = row_bits[sl_col];

  // decision for the item in the exec step
  always_comb begin
    x_status    = STS_OK;
    x_slot      = '0;
    x_owner     = '0;
    x_seated    = '0;
    set_en      = 1'b0;
    set_first   = 1'b0;
    clr_en      = 1'b0;
    clr_all     = 1'b0;
    occ_next    = occ_cnt;
    g_open_next = 1'b0;
    g_rej_next  = 1'b0;
    g_cnt_next  = '0;
    g_first     = !g_open;
    g_reject    = g_first ? ((it_gsize == '0) || (it_gsize > free_now)) : g_rej;
    g_base      = g_first ? '0 : g_cnt;
    case (it_op)
      OP_TAKE_FIRST: begin
        if (it_own == '0) begin
          x_status = STS_BAD;
        end else if (!ff_ok) begin
          x_status = STS_BUSY;
        end else begin
          x_slot    = ff_slot;
          set_en    = 1'b1;
          set_first = 1'b1;
        end
      end
      OP_TAKE_NAMED: begin
        if (!in_range) begin
          x_status = STS_BAD;
        end else begin
          x_slot = it_slot;
          if (it_own == '0) begin
            x_status = STS_BAD;
          end else if (sl_busy) begin
            x_status = STS_BUSY;
          end else begin
            set_en = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (!in_range) begin
          x_status = STS_BAD;
        end else begin
          x_slot = it_slot;
          if (!sl_busy) begin
            x_status = STS_FREE;
          end else begin
            x_owner = OWNER_W'(rd_owner);
            clr_en  = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (!in_range) begin
          x_status = STS_BAD;
        end else begin
          x_slot  = it_slot;
          x_owner = sl_busy ? OWNER_W'(rd_owner) : '0;
        end
      end
      OP_GROUP: begin
        if (g_reject) begin
          x_status = (g_first && (it_gsize == '0)) ? STS_BAD : STS_GROUP_BIG;
          g_cnt_next = '0;
        end else begin
          if (it_own == '0) begin
            x_status = STS_BAD;
          end else if (!ff_ok) begin
            x_status = STS_BUSY;
          end else begin
            x_slot    = ff_slot;
            set_en    = 1'b1;
            set_first = 1'b1;
          end
          x_seated   = g_base + {8'd0, set_en};
          g_cnt_next = x_seated;
        end
        g_open_next = !it_glast;
        g_rej_next  = it_glast ? 1'b0 : g_reject;
        if (it_glast) g_cnt_next = '0;
      end
      OP_CLEAR: begin
        clr_all  = 1'b1;
        occ_next = '0;
      end
      default: begin
        x_status    = STS_BAD;
        g_open_next = g_open;
        g_rej_next  = g_rej;
        g_cnt_next  = g_cnt;
      end
    endcase
    if (set_en) occ_next = occ_cnt + 9'd1;
    if (clr_en) occ_next = occ_cnt - 9'd1;
  end

  assign wipe = cfg_we || (cmd.exec && clr_all);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op    <= opcode_t'(opcode);
      it_slot  <= slot;
      it_own   <= owner[OW-1:0];
      it_gsize <= group_size;
      it_glast <= group_last;
    end
  end

  // look step: pick the row and read the owner memory
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      look_any <= srch_any;
      if (use_search) begin
        row_reg <= srch_row;
      end else if (in_range) begin
        row_reg <= RW'(sl_m1[SLOT_W-1:COL_W]);
      end else begin
        row_reg <= '0;
      end
    end
  end

  // owner memory, free entries are masked by the bitmap
  always_ff @(posedge clk) begin
    if (cmd.exec && set_en) begin
      mem[set_first ? AW'(ff_idx) : AW'(sl_m1)] <= it_own;
    end
    if (cmd.look) begin
      rd_owner <= mem[in_range ? AW'(sl_m1) : '0];
    end
  end

  // occupancy bitmap
  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      for (int r = 0; r < NROWS; r++) occ[r] <= '0;
    end else if (cmd.exec) begin
      if (set_en) occ[row_reg][set_first ? ff_col : sl_col] <= 1'b1;
      if (clr_en) occ[row_reg][sl_col] <= 1'b0;
    end
  end

  // capacity, counts and group run state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CAP_RST[SLOT_W-1:0];
      occ_cnt <= '0;
      g_open  <= 1'b0;
      g_rej   <= 1'b0;
      g_cnt   <= '0;
    end else if (cfg_we) begin
      cap     <= cap_wr;
      occ_cnt <= '0;
      g_open  <= 1'b0;
      g_rej   <= 1'b0;
      g_cnt   <= '0;
    end else if (cmd.exec) begin
      occ_cnt <= occ_next;
      g_open  <= g_open_next;
      g_rej   <= g_rej_next;
      g_cnt   <= g_cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= x_status;
      slot_out     <= x_slot;
      owner_out    <= x_owner;
      occupied     <= occ_next;
      free_slots   <= cap - occ_next;
      group_seated <= x_seated;
    end
  end

`ifndef SYNTH
  a_occ_in_cap: assert property (@(posedge clk) disable iff (rst)
    occ_cnt <= cap)
    else $error("occupied count above capacity");
  a_closed_run_idle: assert property (@(posedge clk) disable iff (rst)
    !g_open |-> (!g_rej && (g_cnt == '0)))
    else $error("group state left over from a closed run");
  a_take_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && set_en && !cfg_we) |=> (occ_cnt == $past(occ_cnt) + 9'd1))
    else $error("take did not raise the occupied count");
`endif

endmodule

/* sv/slot_owner_allocator.sv */
// slot_owner_allocator: table of owner tags for slots 1 to capacity.
// Input stream: one operation per transfer, opcode in tuser, group end in tlast.
// Output stream: one result per input transfer, status in tuser.
// Config: cfg_we/cfg_data write the capacity (clipped to min(511, MAX_SLOTS)); this
// empties the table and closes any group run. Write only while idle.
// Path: item register, look step registers, result register. A new item is taken
// only when idle or in the exec step of the last one, set by the two-step lookup (row
// search over the occupancy bitmap, then the row bits and owner memory read).
// Reset: table empty, capacity min(256, MAX_SLOTS), no clearing pass needed,
// items accepted from the first cycle after reset.
// Stall: one result is held in the output register; one further item may be
// taken and worked, then the input side waits until the result is taken.
// Depends on soa_pkg, soa_ctrl and soa_dp.
module slot_owner_allocator #(
  parameter int MAX_SLOTS  = 256,
  parameter int OWNER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,        // capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // slot[8:0], owner[24:9], group_size[33:25], zero pad
  input  logic [2:0]  s_axis_tuser,    // opcode
  input  logic        s_axis_tlast,    // group_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // slot_out[8:0], owner_out[24:9], occupied[33:25],
                                       // free_slots[42:34], group_seated[51:43], zero pad
  output logic [2:0]  m_axis_tuser     // status
);
  import soa_pkg::*;

  soa_cmd_t          cmd;
  logic [SLOT_W-1:0] r_slot;
  logic [OWNER_W-1:0] r_owner;
  logic [SLOT_W-1:0] r_occ;
  logic [SLOT_W-1:0] r_free;
  logic [SLOT_W-1:0] r_seated;

  // sequencer
  soa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // table datapath
  soa_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .opcode       (s_axis_tuser),
    .slot         (s_axis_tdata[8:0]),
    .owner        (s_axis_tdata[24:9]),
    .group_size   (s_axis_tdata[33:25]),
    .group_last   (s_axis_tlast),
    .status       (m_axis_tuser),
    .slot_out     (r_slot),
    .owner_out    (r_owner),
    .occupied     (r_occ),
    .free_slots   (r_free),
    .group_seated (r_seated)
  );

  // result packing
  assign m_axis_tdata = {4'd0, r_seated, r_free, r_occ, r_owner, r_slot};

endmodule
